// ===== rtl/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared widths, payload types, step codes and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lr_pkg;

  // Coordinate width of every point on the grid.
  localparam int unsigned CoordBits = 10;
  // Signed error term: two more bits for the doubled deltas, one for sign.
  localparam int unsigned ErrBits   = CoordBits + 3;
  // Point count of a run, which can reach the largest span plus one.
  localparam int unsigned StepBits  = CoordBits + 1;
  // Points emitted per accepted item at most.
  localparam int unsigned MaxResults = 64;
  localparam int unsigned BurstBits  = $clog2(MaxResults);

  typedef logic [CoordBits-1:0] coord_t;

  // Step direction of one axis.
  typedef logic [1:0] step_sign_t;
  localparam step_sign_t SignZero = 2'b00;
  localparam step_sign_t SignPos  = 2'b01;
  localparam step_sign_t SignNeg  = 2'b11;

  // Input item: one segment.
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } line_in_t;

  // Result item: one plotted point.
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_point;
  } pixel_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // Capture a new segment from the input item.
    logic setup;  // Pick the major axis and seed the error term.
    logic emit;   // Write one point into the output register.
  } lr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;      // A run is in progress.
    logic at_end;    // The next point is the forced end point.
    logic out_free;  // The output register can take a point this cycle.
  } lr_status_t;

  // Move a coordinate one step in the given direction, wrapping on overflow.
  function automatic coord_t step_coord(coord_t c, step_sign_t s);
    coord_t r;
    case (s)
      SignPos: r = c + coord_t'(1);
      SignNeg: r = c - coord_t'(1);
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/lr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer controller
// Sequences segment capture, setup and point emission, and limits each
// accepted item to a burst of at most MaxResults points.
// ----------------------------------------------------------------------------
module lr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lr_pkg::lr_status_t status_i,
  output lr_pkg::lr_cmd_t    cmd_o
);
  import lr_pkg::*;

  typedef enum logic [1:0] {
    StWait,
    StSetup,
    StEmit
  } state_e;

  state_e               state_q, state_d;
  logic [BurstBits-1:0] burst_q, burst_d;
  logic                 accept;
  logic                 burst_done;

  // The input side is open only while waiting for the next item.
  assign in_stall_o = (state_q != StWait);
  assign accept     = in_valid_i && (state_q == StWait);
  assign burst_done = (burst_q == BurstBits'(MaxResults - 1));

  // Commands to the datapath.
  always_comb begin
    cmd_o.load  = accept && !status_i.busy;
    cmd_o.setup = (state_q == StSetup);
    cmd_o.emit  = (state_q == StEmit) && status_i.out_free;
  end

  // Next state and burst count.
  always_comb begin
    state_d = state_q;
    burst_d = burst_q;
    case (state_q)
      StWait: begin
        if (accept) begin
          burst_d = '0;
          // A run left over from the previous item goes straight on.
          state_d = status_i.busy ? StEmit : StSetup;
        end
      end
      StSetup: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (cmd_o.emit) begin
          burst_d = burst_q + BurstBits'(1);
          if (status_i.at_end || burst_done) begin
            state_d = StWait;
          end
        end
      end
      default: begin
        state_d = StWait;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StWait;
      burst_q <= '0;
    end else begin
      state_q <= state_d;
      burst_q <= burst_d;
    end
  end

endmodule

// ===== rtl/lr_datapath.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer datapath
// Holds the run state (current point, error term, deltas, step signs and the
// end point) and the output register that presents one point at a time.
// ----------------------------------------------------------------------------
module lr_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lr_pkg::line_in_t   in_data_i,
  input  lr_pkg::lr_cmd_t    cmd_i,
  output lr_pkg::lr_status_t status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lr_pkg::pixel_out_t out_data_o
);
  import lr_pkg::*;

  coord_t              cur_x_q, cur_y_q, end_x_q, end_y_q;
  coord_t              major_q, minor_q;
  logic [ErrBits-1:0]  err_q;
  logic [StepBits-1:0] steps_q;
  logic                swapped_q;
  step_sign_t          sign_x_q, sign_y_q;
  logic                busy_q;
  logic                out_valid_q;
  pixel_out_t          out_q;

  logic [CoordBits:0]  dx, dy;
  coord_t              adx, ady;
  step_sign_t          sign_x_n, sign_y_n;
  logic                swap_n;
  coord_t              major_n, minor_n;
  logic [ErrBits-1:0]  two_major, two_minor, err_adv;
  logic                err_ge;
  coord_t              x_adv, y_adv;

  // Deltas and step signs of the incoming segment.
  always_comb begin
    dx  = {1'b0, in_data_i.end_x} - {1'b0, in_data_i.start_x};
    dy  = {1'b0, in_data_i.end_y} - {1'b0, in_data_i.start_y};
    adx = dx[CoordBits] ? coord_t'(-dx) : dx[CoordBits-1:0];
    ady = dy[CoordBits] ? coord_t'(-dy) : dy[CoordBits-1:0];
    if (in_data_i.end_x == in_data_i.start_x) begin
      sign_x_n = SignZero;
    end else begin
      sign_x_n = dx[CoordBits] ? SignNeg : SignPos;
    end
    if (in_data_i.end_y == in_data_i.start_y) begin
      sign_y_n = SignZero;
    end else begin
      sign_y_n = dy[CoordBits] ? SignNeg : SignPos;
    end
  end

  // Major axis choice; the absolute deltas sit in major_q and minor_q as x, y.
  always_comb begin
    swap_n  = (minor_q > major_q);
    major_n = swap_n ? minor_q : major_q;
    minor_n = swap_n ? major_q : minor_q;
  end

  // One Bresenham step: the error term decides whether the minor axis moves.
  always_comb begin
    two_major = ErrBits'({major_q, 1'b0});
    two_minor = ErrBits'({minor_q, 1'b0});
    err_ge    = !err_q[ErrBits-1];
    err_adv   = err_q + two_minor - (err_ge ? two_major : '0);
    x_adv     = cur_x_q;
    y_adv     = cur_y_q;
    if (swapped_q) begin
      y_adv = step_coord(cur_y_q, sign_y_q);
      if (err_ge) begin
        x_adv = step_coord(cur_x_q, sign_x_q);
      end
    end else begin
      x_adv = step_coord(cur_x_q, sign_x_q);
      if (err_ge) begin
        y_adv = step_coord(cur_y_q, sign_y_q);
      end
    end
  end

  // Run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
      major_q   <= '0;
      minor_q   <= '0;
      err_q     <= '0;
      steps_q   <= '0;
      swapped_q <= 1'b0;
      sign_x_q  <= SignZero;
      sign_y_q  <= SignZero;
      busy_q    <= 1'b0;
    end else if (cmd_i.load) begin
      cur_x_q  <= in_data_i.start_x;
      cur_y_q  <= in_data_i.start_y;
      end_x_q  <= in_data_i.end_x;
      end_y_q  <= in_data_i.end_y;
      major_q  <= adx;
      minor_q  <= ady;
      sign_x_q <= sign_x_n;
      sign_y_q <= sign_y_n;
      busy_q   <= 1'b1;
    end else if (cmd_i.setup) begin
      major_q   <= major_n;
      minor_q   <= minor_n;
      swapped_q <= swap_n;
      err_q     <= ErrBits'({minor_n, 1'b0}) - ErrBits'(major_n);
      steps_q   <= {1'b0, major_n} + StepBits'(1);
    end else if (cmd_i.emit) begin
      if (status_o.at_end) begin
        steps_q <= '0;
        busy_q  <= 1'b0;
      end else begin
        cur_x_q <= x_adv;
        cur_y_q <= y_adv;
        err_q   <= err_adv;
        steps_q <= steps_q - StepBits'(1);
      end
    end
  end

  // Output register: filled on emit, emptied when the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (status_o.at_end) begin
        out_q <= '{pixel_x: end_x_q, pixel_y: end_y_q, last_point: 1'b1};
      end else begin
        out_q <= '{pixel_x: cur_x_q, pixel_y: cur_y_q, last_point: 1'b0};
      end
    end
  end

  // Status to the controller.
  always_comb begin
    status_o.busy     = busy_q;
    status_o.at_end   = (steps_q <= StepBits'(1));
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/line_rasterizer.sv =====
// Start: a new segment passes through the setup state before its first point;
// an item that continues a long run goes straight to point emission.
// Throughput: one point per cycle while the output is not stalled; each item
// emits up to 64 points and holds the input closed until its last one.
// Reset: asynchronous, active low; clears the run and the output valid flag.
// ----------------------------------------------------------------------------
// Line rasterizer
// Integer line walk over a grid: one segment in, its covering points out,
// with the exact end point closing each run.
// ----------------------------------------------------------------------------
module line_rasterizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lr_pkg::line_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lr_pkg::pixel_out_t out_data_o
);
  import lr_pkg::*;

  lr_cmd_t    cmd;
  lr_status_t status;

  // Sequencer.
  lr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Run state and output register.
  lr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/lr_checker.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module lr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lr_pkg::pixel_out_t out_data_o
);
  import lr_pkg::*;

  // A stalled result item holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed");

  // The block works on one item at a time: an accept closes the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on two cycles in a row");

  // A clock edge under reset leaves no result item on offer.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result item offered after reset");

  // The input side only opens after a point has been emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> $past(in_stall_o, 1) && out_valid_o)
    else $error("input side opened without an emitted point");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Sends line segments and checks every plotted point against a line walk
// kept in a scoreboard. The test starts with hand-picked segments: zero-length
// lines, several directions, runs longer than one item and a corner-to-corner
// diagonal. Random segments follow, with random idling on both sides, one long
// hold-off on the output and one pause that waits for the block to drain.
// ----------------------------------------------------------------------------
module testbench;
  import lr_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int          RandomItems   = 250;
  localparam int          HoldOffCycles = 300;
  localparam int          SettleCycles  = 16;
  localparam int          ReportLimit   = 10;
  localparam int          CoordMax      = (1 << CoordBits) - 1;

  // Scoreboard: walks each segment the same way the block should and keeps
  // the points it owes in order.
  class pixel_scoreboard;
    pixel_out_t  expected_pixels[$];
    int unsigned mismatches;
    // State of the run in progress.
    bit          run_open;
    bit          y_major;
    coord_t      walk_x, walk_y, goal_x, goal_y;
    step_sign_t  dir_x, dir_y;
    int          err_acc, points_left, major_len, minor_len;

    function new();
      mismatches  = 0;
      run_open    = 1'b0;
      y_major     = 1'b0;
      walk_x      = '0;
      walk_y      = '0;
      goal_x      = '0;
      goal_y      = '0;
      dir_x       = SignZero;
      dir_y       = SignZero;
      err_acc     = 0;
      points_left = 0;
      major_len   = 0;
      minor_len   = 0;
    endfunction

    static function step_sign_t sign_of(int d);
      return (d > 0) ? SignPos : ((d < 0) ? SignNeg : SignZero);
    endfunction

    static function coord_t nudge(coord_t c, step_sign_t s);
      if (s == SignPos) return c + 1'b1;
      if (s == SignNeg) return c - 1'b1;
      return c;
    endfunction

    // Notes one accepted item: opens a new run when none is open, then queues
    // up to one burst of points of the current run.
    function void plot_item(line_in_t seg);
      int         dx, dy, adx, ady, n;
      pixel_out_t pt;
      if (!run_open) begin
        dx          = int'(seg.end_x) - int'(seg.start_x);
        dy          = int'(seg.end_y) - int'(seg.start_y);
        adx         = (dx < 0) ? -dx : dx;
        ady         = (dy < 0) ? -dy : dy;
        walk_x      = seg.start_x;
        walk_y      = seg.start_y;
        goal_x      = seg.end_x;
        goal_y      = seg.end_y;
        dir_x       = sign_of(dx);
        dir_y       = sign_of(dy);
        y_major     = (ady > adx);
        major_len   = y_major ? ady : adx;
        minor_len   = y_major ? adx : ady;
        err_acc     = 2 * minor_len - major_len;
        points_left = major_len + 1;
        run_open    = 1'b1;
      end
      n = 0;
      while (run_open && n < int'(MaxResults)) begin
        if (points_left <= 1) begin
          // The exact end point always closes the run.
          pt.pixel_x    = goal_x;
          pt.pixel_y    = goal_y;
          pt.last_point = 1'b1;
          points_left   = 0;
          run_open      = 1'b0;
        end else begin
          pt.pixel_x    = walk_x;
          pt.pixel_y    = walk_y;
          pt.last_point = 1'b0;
          // The minor axis moves once the error term is non-negative.
          if (err_acc >= 0) begin
            if (y_major) walk_x = nudge(walk_x, dir_x);
            else walk_y = nudge(walk_y, dir_y);
            err_acc -= 2 * major_len;
          end
          if (y_major) walk_y = nudge(walk_y, dir_y);
          else walk_x = nudge(walk_x, dir_x);
          err_acc += 2 * minor_len;
          points_left--;
        end
        expected_pixels.push_back(pt);
        n++;
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= ReportLimit) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Compares one accepted point with the oldest one owed.
    function void check_pixel(pixel_out_t got);
      pixel_out_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected point x=%0d y=%0d last=%0b",
                         got.pixel_x, got.pixel_y, got.last_point));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.last_point !== want.last_point) begin
        report($sformatf("point x=%0d y=%0d last=%0b, expected x=%0d y=%0d last=%0b",
                         got.pixel_x, got.pixel_y, got.last_point,
                         want.pixel_x, want.pixel_y, want.last_point));
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  line_in_t        in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  pixel_out_t      out_data_o;

  pixel_scoreboard board = new();
  int              items_sent;
  bit              steady_in;
  bit              steady_out;
  bit              hold_off;
  bit              holdoff_req;

  line_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offers one item after a random gap, none while steady_in is set, and returns
  // at the edge that accepts it. Valid stays high on return, so the caller either
  // offers the next item at once or lowers valid.
  task automatic offer_item(line_in_t item);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    board.plot_item(item);
    items_sent++;
  endtask

  // Lowers valid and waits until every owed point has come out.
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic line_in_t random_item();
    line_in_t s;
    s.start_x = coord_t'($urandom);
    s.start_y = coord_t'($urandom);
    s.end_x   = coord_t'($urandom);
    s.end_y   = coord_t'($urandom);
    return s;
  endfunction

  // Mostly short segments, some medium ones and a few of any length.
  function automatic line_in_t make_segment();
    line_in_t s;
    int       pick, reach, ex, ey;
    s    = random_item();
    pick = $urandom_range(0, 99);
    if (pick >= 10) begin
      reach = (pick < 75) ? 40 : 200;
      ex    = int'(s.start_x) + int'($urandom_range(0, 2 * reach)) - reach;
      ey    = int'(s.start_y) + int'($urandom_range(0, 2 * reach)) - reach;
      if (ex < 0) ex = 0;
      if (ex > CoordMax) ex = CoordMax;
      if (ey < 0) ey = 0;
      if (ey > CoordMax) ey = CoordMax;
      s.end_x = coord_t'(ex);
      s.end_y = coord_t'(ey);
    end
    return s;
  endfunction

  // Sends one segment and then enough further items to finish its run; their
  // fields are junk that the block must ignore.
  task automatic draw_line(int sx, int sy, int ex, int ey);
    line_in_t s;
    s.start_x = coord_t'(sx);
    s.start_y = coord_t'(sy);
    s.end_x   = coord_t'(ex);
    s.end_y   = coord_t'(ey);
    offer_item(s);
    while (board.run_open) offer_item(random_item());
  endtask

  // Output side: checks accepted points and stalls at random.
  initial begin : pixel_sink
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        board.check_pixel(out_data_o);
        if ($urandom_range(0, 49) == 0) steady_out = !steady_out;
        stall_left = steady_out ? 0 : $urandom_range(0, 7);
      end
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // One long output stall, so the block fills up and stalls its input.
  initial begin : sink_hold_off
    while (!holdoff_req) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Cycle limit for a hung block.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Reset, directed segments, then random segments.
  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    items_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero-length lines at both corners of the grid.
    draw_line(0, 0, 0, 0);
    draw_line(CoordMax, CoordMax, CoordMax, CoordMax);
    // Horizontal, vertical, diagonal and three of the four sign pairings.
    draw_line(5, 7, 20, 7);
    draw_line(9, 30, 9, 3);
    draw_line(10, 10, 40, 40);
    draw_line(100, 50, 37, 61);
    draw_line(100, 50, 89, 3);
    // A run that fills exactly one burst, and one that spills into a second.
    draw_line(0, 0, 63, 0);
    draw_line(3, 0, 3, 64);
    // Corner-to-corner diagonal: the longest run.
    draw_line(CoordMax, 0, 0, CoordMax);
    drain_pixels();

    for (int i = 0; i < RandomItems; i++) begin
      if ($urandom_range(0, 19) == 0) steady_in = !steady_in;
      if (i == 60) holdoff_req <= 1'b1;
      if (i == 150) drain_pixels();
      offer_item(make_segment());
    end
    while (board.run_open) offer_item(random_item());

    drain_pixels();
    repeat (SettleCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
